// ----- hdl/kbt_pkg.sv -----
// Shared constants and types for the keyed block transposition core.
`default_nettype none

package kbt_pkg;

  // Default and absolute largest block size in bytes
  localparam int KEY_LEN_MAX_DEF = 8;
  localparam int KEY_LEN_MAX_ABS = 8;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2,
    CFG_MODE     = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

// ----- hdl/keyed_block_transposition_core.sv -----
// Top level of the keyed block transposition core.
//
// Text bytes stream in on in_* with tlast on the final byte; each block of
// key_length bytes is permuted by the rank order of the key bytes and streamed
// out on out_*, a short tail goes out unchanged, and a text shorter than the
// key gives one item with tuser set. One text byte is taken per cycle when
// the output keeps up: a byte passes from the input register through the
// block store and permutation select into the MAX_KEY_LENGTH-entry output
// shift buffer, which drains one item per cycle while out_tready is high and
// the next block fills. A config write holds off processing while ranks rebuild.
`default_nettype none

module keyed_block_transposition_core #(
  parameter int MAX_KEY_LENGTH = kbt_pkg::KEY_LEN_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // text input: tdata = text_byte[7:0]; tlast = text_end
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,
  input  wire logic                            in_tlast,
  // result output: tdata = out_byte[7:0]; tlast = out_last
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [7:0]                      out_tdata,
  output logic                                 out_tlast,
  // tuser = key_too_long
  output logic                                 out_tuser,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [kbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1;
  localparam int CNT_W = $clog2(MAX_KEY_LENGTH + 1);
  localparam int BW    = kbt_pkg::BYTE_W;
  localparam int LW    = kbt_pkg::LEN_W;

  // configuration registers
  logic [kbt_pkg::CFG_DATA_W-1:0] key_lo_r, key_hi_r;
  logic [LW-1:0]                  key_len_r;
  logic                           enc_r;
  logic                           cfg_dirty_r;

  // rank select
  logic [IDX_W-1:0] sel_nxt [MAX_KEY_LENGTH];
  logic [IDX_W-1:0] sel_r   [MAX_KEY_LENGTH];
  logic [LW-1:0]    len_eff;

  // input register and text state
  logic          in_valid_r;
  logic [BW-1:0] in_byte_r;
  logic          in_end_r;
  logic [BW-1:0] store_r [MAX_KEY_LENGTH];
  logic [BW-1:0] store_new [MAX_KEY_LENGTH];
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             done_r, done_nxt;
  logic [LW-1:0]    count;
  logic             complete, produces, adv, in_acc, cfg_acc;

  // output shift buffer
  logic [BW-1:0] ob_data_r [MAX_KEY_LENGTH];
  logic [BW-1:0] ob_data_nxt [MAX_KEY_LENGTH];
  logic [CNT_W-1:0] ob_cnt_r, ob_cnt_nxt;
  logic             ob_end_r, ob_end_nxt;
  logic             ob_err_r, ob_err_nxt;
  logic             ob_free, ob_pop;

  logic [BW*MAX_KEY_LENGTH-1:0] key_bytes;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      key_len_r   <= LW'(1);
      enc_r       <= 1'b1;
      cfg_dirty_r <= 1'b0;
    end else begin
      cfg_dirty_r <= cfg_acc;
      if (cfg_acc) begin
        unique case (kbt_pkg::cfg_idx_t'(cfg_index))
          kbt_pkg::CFG_KEY_LOW:  key_lo_r  <= cfg_data;
          kbt_pkg::CFG_KEY_HIGH: key_hi_r  <= cfg_data;
          kbt_pkg::CFG_KEY_LEN:  key_len_r <= cfg_data[LW-1:0];
          kbt_pkg::CFG_MODE:     enc_r     <= cfg_data[0];
          default:               ;
        endcase
      end
    end
  end

  // Clamp the block size into 1..MAX_KEY_LENGTH
  always_comb begin
    priority if (key_len_r == '0) begin
      len_eff = LW'(1);
    end else if (key_len_r > LW'(MAX_KEY_LENGTH)) begin
      len_eff = LW'(MAX_KEY_LENGTH);
    end else begin
      len_eff = key_len_r;
    end
  end

  assign key_bytes = (BW*MAX_KEY_LENGTH)'({key_hi_r, key_lo_r});

  kbt_rank #(
    .MAX_KEY_LENGTH(MAX_KEY_LENGTH)
  ) u_rank (
    .key_bytes(key_bytes),
    .key_len  (len_eff),
    .encrypt  (enc_r),
    .src_sel  (sel_nxt)
  );

  // Hold the rank select, rebuilt every cycle from the key registers
  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

  // Handshake and advance control
  assign count    = LW'(fill_r) + LW'(1);
  assign complete = count >= len_eff;
  assign produces = complete | in_end_r;
  assign ob_free  = (ob_cnt_r == '0) || ((ob_cnt_r == CNT_W'(1)) && out_tready);
  assign adv      = in_valid_r & ~cfg_dirty_r & (~produces | ob_free);
  assign in_tready = ~in_valid_r | adv;
  assign in_acc   = in_tvalid & in_tready;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  // Block store with the current byte placed at the fill position
  always_comb begin
    store_new = store_r;
    store_new[fill_r[IDX_W-1:0]] = in_byte_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      store_r[fill_r[IDX_W-1:0]] <= in_byte_r;
    end
  end

  // Advance fill count and block-seen flag
  always_comb begin
    fill_nxt = fill_r;
    done_nxt = done_r;
    if (adv) begin
      priority if (complete && !in_end_r) begin
        fill_nxt = '0;
        done_nxt = 1'b1;
      end else if (!in_end_r) begin
        fill_nxt = CNT_W'(count);
      end else begin
        fill_nxt = '0;
        done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      done_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      done_r <= done_nxt;
    end
  end

  // Load a new result set or shift out one item
  assign ob_pop = out_tvalid & out_tready;

  always_comb begin
    ob_data_nxt = ob_data_r;
    ob_cnt_nxt  = ob_cnt_r;
    ob_end_nxt  = ob_end_r;
    ob_err_nxt  = ob_err_r;
    if (ob_pop) begin
      for (int i = 0; i < MAX_KEY_LENGTH - 1; i++) begin
        ob_data_nxt[i] = ob_data_r[i+1];
      end
      ob_cnt_nxt = ob_cnt_r - CNT_W'(1);
    end
    if (adv && produces) begin
      priority if (complete) begin
        for (int i = 0; i < MAX_KEY_LENGTH; i++) begin
          ob_data_nxt[i] = store_new[sel_r[i]];
        end
        ob_cnt_nxt = CNT_W'(len_eff);
        ob_end_nxt = in_end_r;
        ob_err_nxt = 1'b0;
      end else if (!done_r) begin
        ob_data_nxt[0] = '0;
        ob_cnt_nxt     = CNT_W'(1);
        ob_end_nxt     = 1'b1;
        ob_err_nxt     = 1'b1;
      end else begin
        ob_data_nxt = store_new;
        ob_cnt_nxt  = CNT_W'(count);
        ob_end_nxt  = 1'b1;
        ob_err_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= '0;
      ob_end_r <= 1'b0;
      ob_err_r <= 1'b0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
      ob_end_r <= ob_end_nxt;
      ob_err_r <= ob_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_data_r <= ob_data_nxt;
  end

  // Drive the result channel from the head of the buffer
  assign out_tvalid = ob_cnt_r != '0;
  assign out_tdata  = ob_data_r[0];
  assign out_tlast  = ob_end_r & (ob_cnt_r == CNT_W'(1));
  assign out_tuser  = ob_err_r;

endmodule

`default_nettype wire

// ----- hdl/kbt_rank.sv -----
// Key ranking and permutation source selection for one block.
`default_nettype none

module kbt_rank #(
  parameter int MAX_KEY_LENGTH = kbt_pkg::KEY_LEN_MAX_DEF,
  localparam int IDX_W = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1
) (
  input  wire logic [kbt_pkg::BYTE_W*MAX_KEY_LENGTH-1:0] key_bytes,
  input  wire logic [kbt_pkg::LEN_W-1:0]                 key_len,
  input  wire logic                                      encrypt,
  output logic      [IDX_W-1:0]                          src_sel [MAX_KEY_LENGTH]
);

  logic [kbt_pkg::LEN_W-1:0] rank [MAX_KEY_LENGTH];
  logic [IDX_W-1:0]          inv  [MAX_KEY_LENGTH];

  // Rank each key byte: smaller bytes (signed) plus equal bytes at lower positions
  always_comb begin
    for (int j = 0; j < MAX_KEY_LENGTH; j++) begin
      rank[j] = '0;
      for (int k = 0; k < MAX_KEY_LENGTH; k++) begin
        if ((kbt_pkg::LEN_W'(k) < key_len) &&
            (($signed(key_bytes[kbt_pkg::BYTE_W*j +: kbt_pkg::BYTE_W]) >
              $signed(key_bytes[kbt_pkg::BYTE_W*k +: kbt_pkg::BYTE_W])) ||
             ((key_bytes[kbt_pkg::BYTE_W*j +: kbt_pkg::BYTE_W] ==
               key_bytes[kbt_pkg::BYTE_W*k +: kbt_pkg::BYTE_W]) && (k < j)))) begin
          rank[j] = rank[j] + kbt_pkg::LEN_W'(1);
        end
      end
    end
  end

  // Invert the ranking for the scatter direction
  always_comb begin
    for (int i = 0; i < MAX_KEY_LENGTH; i++) begin
      inv[i] = '0;
      for (int j = 0; j < MAX_KEY_LENGTH; j++) begin
        if ((kbt_pkg::LEN_W'(j) < key_len) && (rank[j] == kbt_pkg::LEN_W'(i))) begin
          inv[i] = inv[i] | IDX_W'(j);
        end
      end
    end
  end

  // Output position i takes stored byte src_sel[i]
  always_comb begin
    for (int i = 0; i < MAX_KEY_LENGTH; i++) begin
      src_sel[i] = encrypt ? rank[i][IDX_W-1:0] : inv[i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/kbt_checker.sv -----
// Port-level checks for the keyed block transposition core, with its bind.
`default_nettype none

module kbt_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [7:0]                      out_tdata,
  input wire logic                            out_tlast,
  input wire logic                            out_tuser
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // An error item always closes the text
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error item without tlast");

  // An error item carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0)
    else $error("error item with nonzero byte");

  // Drop all results on reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

endmodule

bind keyed_block_transposition_core kbt_checker u_kbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);

`default_nettype wire

// ----- dv/keyed_block_transposition_core_tb.sv -----
// Self-checking testbench for the keyed block transposition core.
`timescale 1ns / 1ps

module keyed_block_transposition_core_tb;

  localparam int MAX_KEY        = kbt_pkg::KEY_LEN_MAX_DEF;
  localparam int RANDOM_ITEMS   = 245;
  localparam int DRAIN_CYCLES   = 16;
  localparam int END_CYCLES     = 32;
  localparam int WATCHDOG_LIMIT = 2000;

  // One result item as it leaves the core
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       key_too_long;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed stimulus table
  typedef struct packed {
    row_kind_t         kind;
    kbt_pkg::cfg_idx_t idx;
    logic [31:0]       data;
    logic [7:0]        text_byte;
    logic              text_end;
    bit                typed;
    result_t           res;
  } stim_row_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} stall_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [kbt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kbt_pkg::CFG_DATA_W-1:0] cfg_data;

  // Register mirror, updated when a write is accepted
  logic [31:0] key_low_r  = '0;
  logic [31:0] key_high_r = '0;
  logic [3:0]  key_len_r  = 4'd1;
  logic        enc_mode_r = 1'b1;

  // Text state of the predictor
  logic [7:0]  blk_store [MAX_KEY];
  int unsigned fill_cnt = 0;
  bit          full_block_seen = 1'b0;

  result_t     cipher_out_q [$];

  // Tag that travels with the item being driven
  bit          tag_typed;
  result_t     tag_res;

  int          burst_left = 0;
  int          items_sent = 0;
  int          rand_items = 0;
  int          results_checked = 0;
  int          short_texts = 0;
  int          cfg_writes = 0;
  int          error_count = 0;
  int          idle_cycles;

  stall_mode_t stall_mode = RDY_ALWAYS;
  int          phase_left = 0;
  int          stall_run = 0;

  stim_row_t   dir_rows [$];

  keyed_block_transposition_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Block size in force: zero acts as one, large values clamp
  function automatic int unsigned eff_len();
    int unsigned n;
    n = key_len_r;
    if (n < 1) n = 1;
    if (n > MAX_KEY) n = MAX_KEY;
    return n;
  endfunction

  function automatic logic [7:0] key_at(input int pos);
    logic [31:0] w;
    w = (pos < 4) ? key_low_r : key_high_r;
    return w[(pos % 4) * 8 +: 8];
  endfunction

  // Advance the text state by one byte and queue the bytes it releases
  task automatic transpose_text_byte(input logic [7:0] b, input logic e, input bit emit);
    int unsigned len;
    int unsigned cnt;
    int unsigned r;
    int unsigned rank [MAX_KEY];
    logic [7:0]  perm [MAX_KEY];
    logic signed [7:0] ki;
    logic signed [7:0] kj;
    len = eff_len();
    if (fill_cnt < MAX_KEY) blk_store[fill_cnt] = b;
    cnt = fill_cnt + 1;
    if (cnt > 15) cnt = 15;
    if (cnt >= len) begin
      // Rank key bytes as signed values, ties broken by position
      for (int i = 0; i < len; i++) begin
        ki = key_at(i);
        r = 0;
        for (int j = 0; j < len; j++) begin
          kj = key_at(j);
          if (kj < ki || (kj == ki && j < i)) r++;
        end
        rank[i] = r;
      end
      for (int j = 0; j < len; j++) begin
        if (enc_mode_r) perm[j] = blk_store[rank[j]];
        else perm[rank[j]] = blk_store[j];
      end
      if (emit)
        for (int j = 0; j < len; j++)
          cipher_out_q.push_back({perm[j], e && (j == len - 1), 1'b0});
      fill_cnt = 0;
      full_block_seen = !e;
    end else if (!e) begin
      fill_cnt = cnt;
    end else if (!full_block_seen) begin
      // Text ended before the first block filled
      if (emit) cipher_out_q.push_back({8'h00, 1'b1, 1'b1});
      fill_cnt = 0;
    end else begin
      // Pass the short tail through unchanged
      if (emit)
        for (int j = 0; j < cnt; j++)
          cipher_out_q.push_back({blk_store[j], j == cnt - 1, 1'b0});
      fill_cnt = 0;
      full_block_seen = 1'b0;
    end
  endtask

  // Predict on accepted input, mirror registers, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (kbt_pkg::cfg_idx_t'(cfg_index))
          kbt_pkg::CFG_KEY_LOW:  key_low_r  = cfg_data;
          kbt_pkg::CFG_KEY_HIGH: key_high_r = cfg_data;
          kbt_pkg::CFG_KEY_LEN:  key_len_r  = cfg_data[3:0];
          kbt_pkg::CFG_MODE:     enc_mode_r = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        transpose_text_byte(in_tdata, in_tlast, !tag_typed);
        if (tag_typed) cipher_out_q.push_back(tag_res);
      end
      if (out_tvalid && out_tready) begin
        if (cipher_out_q.size() == 0) begin
          $error("unexpected result item: out_byte %02h out_last %0b key_too_long %0b",
                 out_tdata, out_tlast, out_tuser);
          error_count++;
        end else begin
          result_t want;
          want = cipher_out_q.pop_front();
          results_checked++;
          if (out_tuser) short_texts++;
          if (out_tdata !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_tdata);
            error_count++;
          end
          if (out_tlast !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, out_tlast);
            error_count++;
          end
          if (out_tuser !== want.key_too_long) begin
            $error("key_too_long: expected %0b, got %0b", want.key_too_long, out_tuser);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: change stall behavior at the end of each random phase, cap stall runs
  always @(negedge clk) begin
    logic rdy;
    if (phase_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      phase_left = $urandom_range(20, 120);
    end
    phase_left--;
    case (stall_mode)
      RDY_ALWAYS: rdy = 1'b1;
      RDY_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
      RDY_RARELY: rdy = ($urandom_range(0, 3) == 0);
      default:    rdy = ((phase_left & 4) != 0);
    endcase
    if (!rdy && stall_run >= 7) rdy = 1'b1;
    stall_run = rdy ? 0 : stall_run + 1;
    out_tready = rdy;
  end

  // Drive one text byte, opening a new burst after a random gap when due
  task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
                           input result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = e;
    tag_typed = typed;
    tag_res   = res;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // Write a register once all results are out and the core has settled
  task automatic write_reg(input kbt_pkg::cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (cipher_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    burst_left = 0;
  endtask

  // Key words biased toward signed extremes and repeated bytes
  function automatic logic [31:0] rand_key_word();
    logic [31:0] w;
    for (int k = 0; k < 4; k++)
      case ($urandom_range(0, 7))
        0: w[k*8 +: 8] = 8'h00;
        1: w[k*8 +: 8] = 8'h7F;
        2: w[k*8 +: 8] = 8'h80;
        3: w[k*8 +: 8] = 8'hFF;
        4: w[k*8 +: 8] = 8'h41;
        default: w[k*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    return w;
  endfunction

  task automatic reconfigure_random();
    kbt_pkg::cfg_idx_t idx;
    logic [31:0]       data;
    int unsigned       lenv;
    idx = kbt_pkg::cfg_idx_t'($urandom_range(0, 3));
    case (idx)
      kbt_pkg::CFG_KEY_LOW, kbt_pkg::CFG_KEY_HIGH: data = rand_key_word();
      kbt_pkg::CFG_KEY_LEN: begin
        lenv = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 15);
        data = ($urandom() & 32'hFFFF_FFF0) | lenv;
      end
      default: data = ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1);
    endcase
    write_reg(idx, data);
  endtask

  function automatic void add_item(input logic [7:0] b, input logic e, input bit typed,
                                   input result_t res);
    dir_rows.push_back({ROW_ITEM, kbt_pkg::CFG_KEY_LOW, 32'h0, b, e, typed, res});
  endfunction

  function automatic void add_cfg(input kbt_pkg::cfg_idx_t idx, input logic [31:0] data);
    dir_rows.push_back({ROW_CFG, idx, data, 8'h00, 1'b0, 1'b0, result_t'(0)});
  endfunction

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned text_len;
    int unsigned mid;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tag_typed  = 1'b0;
    tag_res    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset key of length one: bytes pass straight through
    add_item(8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0});
    add_item(8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b0});
    // Signed extremes in the low word, equal bytes in the high word
    add_cfg(kbt_pkg::CFG_KEY_LOW,  32'h807F_00FF);
    add_cfg(kbt_pkg::CFG_KEY_HIGH, 32'h0101_0101);
    add_cfg(kbt_pkg::CFG_KEY_LEN,  32'd8);
    // Text shorter than the key
    add_item(8'h11, 1'b0, 1'b0, '0);
    add_item(8'h22, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1});
    // Full block that ends the text
    for (int k = 0; k < 8; k++) add_item(8'(8'h10 + k), k == 7, 1'b0, '0);
    // Decrypt: one block then a short tail
    add_cfg(kbt_pkg::CFG_MODE,    32'd0);
    add_cfg(kbt_pkg::CFG_KEY_LEN, 32'd4);
    for (int k = 0; k < 5; k++) add_item(8'(8'hA0 + k), k == 4, 1'b0, '0);
    // Oversized length clamps; then shrink it with bytes already held
    add_cfg(kbt_pkg::CFG_KEY_LEN, 32'd15);
    add_cfg(kbt_pkg::CFG_MODE,    32'd1);
    for (int k = 0; k < 5; k++) add_item(8'(8'hC0 + k), 1'b0, 1'b0, '0);
    add_cfg(kbt_pkg::CFG_KEY_LEN, 32'd3);
    add_item(8'hC5, 1'b1, 1'b0, '0);
    // Length zero acts as one
    add_cfg(kbt_pkg::CFG_KEY_LEN, 32'd0);
    add_item(8'h3C, 1'b1, 1'b1, {8'h3C, 1'b1, 1'b0});

    foreach (dir_rows[k])
      if (dir_rows[k].kind == ROW_CFG)
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      else
        send_byte(dir_rows[k].text_byte, dir_rows[k].text_end, dir_rows[k].typed,
                  dir_rows[k].res);

    // Random texts, each complete, with occasional changes mid-text
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) reconfigure_random();
      len = eff_len();
      if ($urandom_range(0, 7) == 0) text_len = $urandom_range(1, len);
      else text_len = $urandom_range(1, 3 * len + 2);
      mid = ($urandom_range(0, 7) == 0 && text_len > 1) ? $urandom_range(1, text_len - 1) : 0;
      for (int k = 0; k < text_len; k++) begin
        if (mid != 0 && k == mid) reconfigure_random();
        send_byte(8'($urandom_range(0, 255)), k == text_len - 1, 1'b0, '0);
        rand_items++;
      end
    end

    // Drain and let the core settle
    @(negedge clk);
    in_tvalid = 1'b0;
    while (cipher_out_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (cipher_out_q.size() != 0) begin
      $error("%0d result items never arrived", cipher_out_q.size());
      error_count++;
    end

    $display("Sent %0d text bytes (%0d random) across %0d register writes;",
             items_sent, rand_items, cfg_writes);
    $display("checked %0d result bytes, %0d of them short-text errors, %0d mismatches.",
             results_checked, short_texts, error_count);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/kbt_pkg.sv
hdl/kbt_rank.sv
hdl/keyed_block_transposition_core.sv
hdl/kbt_checker.sv
dv/keyed_block_transposition_core_tb.sv
